>>> hdl/assert_macros.svh
// Shared assertion macros. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock outside reset.
`define ASSERT_AT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/scm_pkg.sv
package scm_pkg;

    localparam int DMEM_WORDS = 64;
    localparam int DMEM_AW    = $clog2(DMEM_WORDS);
    localparam logic [31:0] DMEM_WORDS_W = 32'(DMEM_WORDS);

    // item kinds
    localparam logic [1:0] FUNC_EXEC  = 2'd0;
    localparam logic [1:0] FUNC_LDREG = 2'd1;
    localparam logic [1:0] FUNC_LDMEM = 2'd2;

    // opcodes
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_JMP1  = 6'd1;
    localparam logic [5:0] OP_JMP2  = 6'd2;
    localparam logic [5:0] OP_JMP3  = 6'd3;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    // R-type function codes
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_NOR = 6'd39;
    localparam logic [5:0] FN_SLT = 6'd42;

    typedef struct packed {
        logic [1:0]         func;
        logic [31:0]        instr_word;
        logic [5:0]         load_index;
        logic signed [31:0] load_value;
    } scm_in_t;

    typedef struct packed {
        logic [31:0]        pc_after;
        logic               reg_written;
        logic [4:0]         dest_reg;
        logic signed [31:0] written_value;
        logic               mem_written;
        logic [31:0]        mem_byte_address;
        logic signed [31:0] stored_value;
        logic               branch_taken;
    } scm_out_t;

    // execute-stage result plus memory control
    typedef struct packed {
        logic [31:0]         pc_next;
        logic                reg_written;
        logic [4:0]          dest_reg;
        logic [31:0]         written_value;
        logic                ld;
        logic                ld_ok;
        logic                mem_written;
        logic [DMEM_AW-1:0]  dm_idx;
        logic [31:0]         mem_byte_address;
        logic [31:0]         stored_value;
        logic                branch_taken;
    } scm_exec_t;

    // register write in flight
    typedef struct packed {
        logic        en;
        logic [4:0]  dest;
        logic [31:0] value;
    } scm_wb_t;

endpackage

>>> hdl/scm_ram.sv
module scm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/scm_regfile.sv
`include "assert_macros.svh"

module scm_regfile (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [4:0]      rd_addr_a,
    input  logic [4:0]      rd_addr_b,
    input  scm_pkg::scm_wb_t wb,
    input  logic            commit,
    output logic [31:0]     op_a,
    output logic [31:0]     op_b
);

    import scm_pkg::*;

    logic [31:0] valid_reg;
    logic        last_vld_reg;
    logic [4:0]  last_dest_reg;
    logic [31:0] last_val_reg;
    logic [4:0]  addr_a_reg;
    logic [4:0]  addr_b_reg;
    logic [31:0] q_a;
    logic [31:0] q_b;
    logic        wr;

    assign wr = commit && wb.en;

    // two copies give two read ports
    scm_ram #(.WIDTH(32), .DEPTH(32)) u_bank_a (
        .clk   (clk),
        .we    (wr),
        .waddr (wb.dest),
        .wdata (wb.value),
        .re    (rd_en),
        .raddr (rd_addr_a),
        .rdata (q_a)
    );

    scm_ram #(.WIDTH(32), .DEPTH(32)) u_bank_b (
        .clk   (clk),
        .we    (wr),
        .waddr (wb.dest),
        .wdata (wb.value),
        .re    (rd_en),
        .raddr (rd_addr_b),
        .rdata (q_b)
    );

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
        end
        if (wr)
        begin
            last_dest_reg <= wb.dest;
            last_val_reg  <= wb.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            last_vld_reg <= 1'b0;
        end
        else if (wr)
        begin
            valid_reg[wb.dest] <= 1'b1;
            last_vld_reg       <= 1'b1;
        end
    end

    // pending write, then the write the bank read missed, then storage; never-written registers read zero
    function automatic logic [31:0] pick(input logic [4:0] a, input logic [31:0] q);
        logic [31:0] v;
        if (wb.en && wb.dest == a)
            v = wb.value;
        else if (last_vld_reg && last_dest_reg == a)
            v = last_val_reg;
        else if (valid_reg[a])
            v = q;
        else
            v = '0;
        return v;
    endfunction

    assign op_a = pick(addr_a_reg, q_a);
    assign op_b = pick(addr_b_reg, q_b);

    `ASSERT_NEVER(a_r0_never_valid, valid_reg[0], "register zero marked written")
    `ASSERT_NEVER(a_no_r0_write, wb.en && wb.dest == 5'd0, "write aimed at register zero")

endmodule

>>> hdl/scm_exec.sv
module scm_exec (
    input  scm_pkg::scm_in_t   item,
    input  logic [31:0]        pc,
    input  logic [31:0]        op_a,
    input  logic [31:0]        op_b,
    output scm_pkg::scm_exec_t res
);

    import scm_pkg::*;

    logic [31:0] w;
    logic [5:0]  op;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [5:0]  fc;
    logic [31:0] imm;
    logic [31:0] seq;
    logic [31:0] addr;
    logic [31:0] widx;
    logic [31:0] li_w;

    assign w    = item.instr_word;
    assign op   = w[31:26];
    assign rt   = w[20:16];
    assign rd   = w[15:11];
    assign fc   = w[5:0];
    assign imm  = {{16{w[15]}}, w[15:0]};
    assign seq  = pc + 32'd4;
    assign addr = op_a + imm;
    assign widx = {2'b00, addr[31:2]};
    assign li_w = {26'd0, item.load_index};

    always_comb
    begin
        res = '0;
        res.pc_next = pc;
        case (item.func)
            FUNC_EXEC:
            begin
                res.pc_next = seq;
                case (op)
                    OP_RTYPE:
                    begin
                        res.reg_written = (rd != 5'd0);
                        case (fc)
                            FN_ADD: res.written_value = op_a + op_b;
                            FN_SUB: res.written_value = op_a - op_b;
                            FN_AND: res.written_value = op_a & op_b;
                            FN_OR:  res.written_value = op_a | op_b;
                            FN_NOR: res.written_value = ~(op_a | op_b);
                            FN_SLT: res.written_value =
                                {31'd0, $signed(op_a) < $signed(op_b)};
                            default: res.reg_written = 1'b0;
                        endcase
                        if (res.reg_written)
                            res.dest_reg = rd;
                        else
                            res.written_value = '0;
                    end
                    OP_JMP1, OP_JMP2, OP_JMP3:
                    begin
                        res.pc_next      = {4'd0, w[25:0], 2'b00} + seq;
                        res.branch_taken = 1'b1;
                    end
                    OP_LW:
                    begin
                        // value arrives from data memory in the result stage
                        res.dm_idx = widx[DMEM_AW-1:0];
                        if (rt != 5'd0)
                        begin
                            res.reg_written = 1'b1;
                            res.dest_reg    = rt;
                            res.ld          = 1'b1;
                            res.ld_ok       = (widx < DMEM_WORDS_W);
                        end
                    end
                    OP_SW:
                    begin
                        res.dm_idx = widx[DMEM_AW-1:0];
                        if (widx < DMEM_WORDS_W)
                        begin
                            res.mem_written      = 1'b1;
                            res.mem_byte_address = addr;
                            res.stored_value     = op_b;
                        end
                    end
                    OP_BEQ:
                    begin
                        if (op_a == op_b)
                        begin
                            res.pc_next      = seq + {imm[29:0], 2'b00};
                            res.branch_taken = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_LDREG:
            begin
                if (!item.load_index[5] && item.load_index[4:0] != 5'd0)
                begin
                    res.reg_written   = 1'b1;
                    res.dest_reg      = item.load_index[4:0];
                    res.written_value = item.load_value;
                end
            end
            FUNC_LDMEM:
            begin
                res.dm_idx = li_w[DMEM_AW-1:0];
                if (li_w < DMEM_WORDS_W)
                begin
                    res.mem_written      = 1'b1;
                    res.mem_byte_address = {24'd0, item.load_index, 2'b00};
                    res.stored_value     = item.load_value;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> hdl/single_cycle_mips_subset_core.sv
// An accepted item moves to the execute register, then to the result register.
// Throughput: one item per cycle while result beats are taken; the execute
// stage and result register each hold one item. A result beat held back stalls
// the execute stage, and input stops once that stage is occupied.
// Reset: PC, registers and data memory read as zero. After rst_n rises the core
// zeroes data memory, one word per cycle, before it accepts its first beat.
`include "assert_macros.svh"

module single_cycle_mips_subset_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  scm_pkg::scm_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output scm_pkg::scm_out_t out_data
);

    import scm_pkg::*;

    // ---------------------------------------------------------------------
    // Pipeline
    //   accept : beat lands in the execute register; register file banks
    //            read rs/rt of the incoming word at the same edge.
    //   execute: operands (with forwarding), ALU, branch, address; PC and
    //            data memory stores commit when the item leaves; loads
    //            issue their memory read at that edge.
    //   result : result register drives the output beat; load data comes
    //            from the memory read register. Register file write
    //            happens when the result beat is taken.
    // ---------------------------------------------------------------------

    logic               s1_vld_reg;
    scm_in_t            s1_data_reg;
    logic               s2_vld_reg;
    scm_exec_t          s2_res_reg;
    logic [31:0]        pc_reg;

    // post-reset clear of data memory
    logic               clr_active_reg;
    logic [DMEM_AW-1:0] clr_idx_reg;

    logic               accept;
    logic               s1_adv;
    logic               commit;
    logic [31:0]        op_a;
    logic [31:0]        op_b;
    scm_exec_t          ex;
    scm_wb_t            wb;
    logic [31:0]        dm_q;
    logic               dm_we;
    logic [DMEM_AW-1:0] dm_waddr;
    logic [31:0]        dm_wdata;
    logic [31:0]        wb_value;

    assign s1_adv   = s1_vld_reg && (!s2_vld_reg || out_ready);
    assign in_ready = !clr_active_reg && (!s1_vld_reg || s1_adv);
    assign accept   = in_valid && in_ready;
    assign commit   = out_valid && out_ready;

    // register file with forwarding from the result stage
    scm_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (in_data.instr_word[25:21]),
        .rd_addr_b (in_data.instr_word[20:16]),
        .wb        (wb),
        .commit    (commit),
        .op_a      (op_a),
        .op_b      (op_b)
    );

    scm_exec u_exec (
        .item (s1_data_reg),
        .pc   (pc_reg),
        .op_a (op_a),
        .op_b (op_b),
        .res  (ex)
    );

    // data memory: clear sweep owns the write port until done
    assign dm_we    = clr_active_reg || (s1_adv && ex.mem_written);
    assign dm_waddr = clr_active_reg ? clr_idx_reg : ex.dm_idx;
    assign dm_wdata = clr_active_reg ? 32'd0 : ex.stored_value;

    scm_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (s1_adv && ex.ld),
        .raddr (ex.dm_idx),
        .rdata (dm_q)
    );

    // out-of-range load reads as zero
    assign wb_value = s2_res_reg.ld ? (s2_res_reg.ld_ok ? dm_q : 32'd0)
                                    : s2_res_reg.written_value;

    assign wb.en    = s2_vld_reg && s2_res_reg.reg_written;
    assign wb.dest  = s2_res_reg.dest_reg;
    assign wb.value = wb_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            pc_reg         <= '0;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_idx_reg == DMEM_AW'(DMEM_WORDS - 1))
                    clr_active_reg <= 1'b0;
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (accept)
                s1_vld_reg <= 1'b1;
            else if (s1_adv)
                s1_vld_reg <= 1'b0;
            if (s1_adv)
            begin
                s2_vld_reg <= 1'b1;
                pc_reg     <= ex.pc_next;
            end
            else if (commit)
                s2_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_data_reg <= in_data;
        if (s1_adv)
            s2_res_reg <= ex;
    end

    assign out_valid                 = s2_vld_reg;
    assign out_data.pc_after         = s2_res_reg.pc_next;
    assign out_data.reg_written      = s2_res_reg.reg_written;
    assign out_data.dest_reg         = s2_res_reg.dest_reg;
    assign out_data.written_value    = wb_value;
    assign out_data.mem_written      = s2_res_reg.mem_written;
    assign out_data.mem_byte_address = s2_res_reg.mem_byte_address;
    assign out_data.stored_value     = s2_res_reg.stored_value;
    assign out_data.branch_taken     = s2_res_reg.branch_taken;

    `ASSERT_AT(a_adv_fills_s2, s1_adv |=> s2_vld_reg, "execute item lost on advance")
    `ASSERT_AT(a_pc_hold, !s1_adv |=> $stable(pc_reg), "PC moved without an item")
    `ASSERT_AT(a_clr_empty, clr_active_reg |-> (!s1_vld_reg && !s2_vld_reg), "item during clear")
    `ASSERT_NEVER(a_ld_st_excl, s1_vld_reg && ex.ld && ex.mem_written, "load and store at once")

endmodule

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scm_pkg::*;

    // Codes the package does not name: the spare item kind and an R-type
    // function code that the core does not implement.
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [5:0] FN_UNDEF  = 6'd1;

    localparam int unsigned RANDOM_PER_PHASE = 350;
    localparam int unsigned TAIL_CYCLES      = 8;    // settle time after the final drain, with margin
    // Quiet-cycle limit: covers the memory clear after reset and the longest
    // plausible run of random stalls, several times over.
    localparam int unsigned QUIET_LIMIT      = 2000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    scm_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    scm_out_t out_data;

    single_cycle_mips_subset_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial forever #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Architectural shadow of the core: PC, register file, data memory.
    // Updated once per accepted input beat, in acceptance order.
    // ------------------------------------------------------------------
    logic [31:0] arch_pc;
    logic [31:0] arch_regs [32];
    logic [31:0] arch_dmem [DMEM_WORDS];

    scm_in_t  program_beats[$];     // beats waiting for the driver
    scm_out_t pending_retires[$];   // predicted result beats, oldest first

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned beats_sent   = 0;
    int unsigned retires_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned n_reg_writes = 0;
    int unsigned n_stores     = 0;
    int unsigned n_redirects  = 0;

    initial begin
        arch_pc = '0;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (arch_dmem[i]) arch_dmem[i] = '0;
    end

    // Register write with the r0 rule: writes to register zero vanish and
    // are not reported.
    function automatic void write_gpr(inout scm_out_t r, input logic [4:0] dest,
                                      input logic [31:0] value);
        if (dest != 5'd0) begin
            arch_regs[dest] = value;
            r.reg_written   = 1'b1;
            r.dest_reg      = dest;
            r.written_value = value;
        end
    endfunction

    // Applies one beat to the shadow state and returns the result it causes.
    function automatic scm_out_t retire_beat(scm_in_t beat);
        scm_out_t    r;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd;
        logic [31:0] imm, a, b, seq, npc, addr;
        r = '0;
        case (beat.func)
            FUNC_LDREG: begin
                if (beat.load_index < 32)
                    write_gpr(r, beat.load_index[4:0], beat.load_value);
            end
            FUNC_LDMEM: begin
                if (beat.load_index < DMEM_WORDS) begin
                    arch_dmem[beat.load_index] = beat.load_value;
                    r.mem_written      = 1'b1;
                    r.mem_byte_address = {24'd0, beat.load_index, 2'b00};
                    r.stored_value     = beat.load_value;
                end
            end
            FUNC_EXEC: begin
                op  = beat.instr_word[31:26];
                rs  = beat.instr_word[25:21];
                rt  = beat.instr_word[20:16];
                rd  = beat.instr_word[15:11];
                fn  = beat.instr_word[5:0];
                imm = {{16{beat.instr_word[15]}}, beat.instr_word[15:0]};
                a   = arch_regs[rs];
                b   = arch_regs[rt];
                seq = arch_pc + 32'd4;
                npc = seq;
                addr = a + imm;
                case (op)
                    OP_RTYPE: begin
                        case (fn)
                            FN_ADD: write_gpr(r, rd, a + b);
                            FN_SUB: write_gpr(r, rd, a - b);
                            FN_AND: write_gpr(r, rd, a & b);
                            FN_OR:  write_gpr(r, rd, a | b);
                            FN_NOR: write_gpr(r, rd, ~(a | b));
                            FN_SLT: write_gpr(r, rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
                            default: ;
                        endcase
                    end
                    OP_JMP1, OP_JMP2, OP_JMP3: begin
                        npc = {beat.instr_word[25:0], 2'b00} + seq;
                        r.branch_taken = 1'b1;
                    end
                    OP_LW: begin
                        // out-of-range word reads as zero
                        write_gpr(r, rt, ((addr >> 2) < DMEM_WORDS_W) ?
                                         arch_dmem[addr[DMEM_AW+1:2]] : 32'd0);
                    end
                    OP_SW: begin
                        // out-of-range store is dropped silently
                        if ((addr >> 2) < DMEM_WORDS_W) begin
                            arch_dmem[addr[DMEM_AW+1:2]] = b;
                            r.mem_written      = 1'b1;
                            r.mem_byte_address = addr;
                            r.stored_value     = b;
                        end
                    end
                    OP_BEQ: begin
                        if (a == b) begin
                            npc = seq + (imm << 2);
                            r.branch_taken = 1'b1;
                        end
                    end
                    default: ;
                endcase
                arch_pc = npc;
            end
            default: ;   // spare kind: nothing changes
        endcase
        r.pc_after = arch_pc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Instruction encoders and beat builders
    // ------------------------------------------------------------------
    function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs,
                                          logic [4:0] rt, logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic scm_in_t make_beat(logic [1:0] func, logic [31:0] word,
                                          logic [5:0] idx, logic [31:0] value);
        scm_in_t b;
        b.func       = func;
        b.instr_word = word;
        b.load_index = idx;
        b.load_value = value;
        return b;
    endfunction

    // Random beat, weighted toward well-formed instructions whose operands
    // actually hit memory and registers. Base register zero with a small
    // offset lands around the end of data memory, so loads and stores see
    // both in-range and dropped addresses.
    function automatic scm_in_t random_beat();
        scm_in_t     b;
        int unsigned pick;
        logic [4:0]  rs, rt, rd;
        logic [5:0]  fn_pool [6];
        logic [5:0]  op;
        logic [15:0] imm;
        fn_pool = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_NOR, FN_SLT};
        b = make_beat(FUNC_EXEC, $urandom, 6'($urandom_range(0, 63)), $urandom);
        rs = 5'($urandom);
        rt = 5'($urandom);
        rd = 5'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            b.func = FUNC_LDREG;
        end else if (pick < 15) begin
            // small word-aligned value: makes a useful base register
            b.func       = FUNC_LDREG;
            b.load_index = 6'($urandom_range(1, 31));
            b.load_value = 32'($urandom_range(0, 70)) << 2;
        end else if (pick < 21) begin
            b.func = FUNC_LDMEM;
        end else if (pick < 23) begin
            b.func = FUNC_NONE;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                b.instr_word = rtype(rs, rt, rd, fn_pool[$urandom_range(0, 5)]);
                b.instr_word[10:6] = 5'($urandom);
            end else if (pick < 40) begin
                b.instr_word = rtype(rs, rt, rd, 6'($urandom));
            end else if (pick < 64) begin
                op  = (pick < 52) ? OP_LW : OP_SW;
                imm = $urandom_range(0, 1) ? 16'($urandom_range(0, 280)) : 16'($urandom);
                b.instr_word = itype(op, $urandom_range(0, 2) == 0 ? 5'd0 : rs, rt, imm);
            end else if (pick < 76) begin
                // half the branches compare a register with itself: taken
                b.instr_word = itype(OP_BEQ, rs, $urandom_range(0, 1) ? rs : rt, 16'($urandom));
            end else if (pick < 84) begin
                b.instr_word = {6'($urandom_range(1, 3)), 26'($urandom)};
            end
            // otherwise a fully random word
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one beat in flight; payload held until accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            if (in_valid && in_ready) begin
                pending_retires.push_back(retire_beat(in_data));
                beats_sent++;
            end
            if (!in_valid || in_ready) begin
                if (program_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= program_beats.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] retire %0d: %s got %h want %h", $realtime, retires_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_retire(scm_out_t got, scm_out_t want);
        if (got.pc_after !== want.pc_after)
            report_mismatch("pc_after", got.pc_after, want.pc_after);
        if (got.reg_written !== want.reg_written)
            report_mismatch("reg_written", got.reg_written, want.reg_written);
        if (got.dest_reg !== want.dest_reg)
            report_mismatch("dest_reg", got.dest_reg, want.dest_reg);
        if (got.written_value !== want.written_value)
            report_mismatch("written_value", got.written_value, want.written_value);
        if (got.mem_written !== want.mem_written)
            report_mismatch("mem_written", got.mem_written, want.mem_written);
        if (got.mem_byte_address !== want.mem_byte_address)
            report_mismatch("mem_byte_address", got.mem_byte_address, want.mem_byte_address);
        if (got.stored_value !== want.stored_value)
            report_mismatch("stored_value", got.stored_value, want.stored_value);
        if (got.branch_taken !== want.branch_taken)
            report_mismatch("branch_taken", got.branch_taken, want.branch_taken);
        n_reg_writes += want.reg_written;
        n_stores     += want.mem_written;
        n_redirects  += want.branch_taken;
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_retires.size() == 0)
                report_mismatch("unexpected beat, pc_after", out_data.pc_after, '0);
            else
                check_retire(out_data, pending_retires.pop_front());
            retires_seen++;
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 $realtime, QUIET_LIMIT, pending_retires.size());
        $display("single_cycle_mips_subset_core: mismatch");
        $finish;
    end

    // Sender pause: returns at a falling edge once every queued beat is
    // accepted and every predicted result has been checked.
    task automatic wait_drained();
        do @(negedge clk);
        while (program_beats.size() != 0 || in_valid || pending_retires.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned idle_plan  [4];
        int unsigned stall_plan [4];
        int unsigned directed_count;
        idle_plan  = '{0, 52, 0, 6};
        stall_plan = '{0, 0, 52, 6};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes, each operation and the corner cases.
        program_beats.push_back(make_beat(FUNC_LDREG, '0, 6'd1, 32'h7FFF_FFFF));
        program_beats.push_back(make_beat(FUNC_LDREG, '0, 6'd2, 32'h8000_0000));
        // preload of r0 is dropped
        program_beats.push_back(make_beat(FUNC_LDREG, '0, 6'd0, 32'h1234_5678));
        // register index past the file: ignored
        program_beats.push_back(make_beat(FUNC_LDREG, '0, 6'd45, 32'hDEAD_BEEF));
        program_beats.push_back(make_beat(FUNC_LDMEM, '0, 6'd63, 32'hFFFF_FFFF));
        program_beats.push_back(make_beat(FUNC_EXEC, rtype(1, 2, 3, FN_ADD), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, rtype(1, 2, 4, FN_SUB), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, rtype(1, 2, 5, FN_AND), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, rtype(1, 2, 6, FN_OR), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, rtype(1, 2, 7, FN_NOR), '0, '0));
        // slt is signed: min < max, not the other way round
        program_beats.push_back(make_beat(FUNC_EXEC, rtype(2, 1, 8, FN_SLT), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, rtype(1, 2, 9, FN_SLT), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, rtype(1, 1, 0, FN_ADD), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, rtype(1, 2, 10, FN_UNDEF), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, itype(OP_SW, 0, 1, 16'd8), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, itype(OP_LW, 0, 11, 16'd8), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, itype(OP_LW, 0, 12, 16'd252), '0, '0));
        // just past the end of data memory: reads zero
        program_beats.push_back(make_beat(FUNC_EXEC, itype(OP_LW, 0, 13, 16'd256), '0, '0));
        // negative offset wraps to the top of the address space: dropped
        program_beats.push_back(make_beat(FUNC_EXEC, itype(OP_SW, 0, 2, 16'hFFFC), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, itype(OP_BEQ, 1, 1, 16'hFFFF), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, itype(OP_BEQ, 1, 2, 16'h7FFF), '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, {OP_JMP1, 26'h3FF_FFFF}, '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, {OP_JMP2, 26'h000_0000}, '0, '0));
        program_beats.push_back(make_beat(FUNC_EXEC, {OP_JMP3, 26'h000_0100}, '0, '0));
        // unimplemented opcode, then the spare item kind
        program_beats.push_back(make_beat(FUNC_EXEC, 32'hFFFF_FFFF, '0, '0));
        program_beats.push_back(make_beat(FUNC_NONE, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF));
        directed_count = program_beats.size();

        // Full drain before the random part: sender holds off until every
        // predicted result has been checked.
        wait_drained();

        // Random part, one flow-control phase at a time, draining in between.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
                program_beats.push_back(random_beat());
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d beats (%0d directed) in four flow-control phases",
                 beats_sent, directed_count);
        $display("results checked %0d: %0d register writes, %0d stores, %0d redirects",
                 retires_seen, n_reg_writes, n_stores, n_redirects);
        if (mismatches == 0)
            $display("single_cycle_mips_subset_core: match");
        else
            $display("single_cycle_mips_subset_core: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/scm_pkg.sv
hdl/scm_ram.sv
hdl/scm_regfile.sv
hdl/scm_exec.sv
hdl/single_cycle_mips_subset_core.sv
test/tb_top.sv
